// ----- hw/rtl/rans64_pkg.sv -----
// Shared constants and codes for the rANS encoder.
package rans64_pkg;

   localparam int MaxSymbols = 256;
   localparam int SymW       = $clog2(MaxSymbols);
   localparam int WordW      = 32;
   localparam int StateW     = 64;
   localparam int ScaleW     = 5;
   localparam int CountW     = 9;
   localparam int StartW     = WordW + SymW;
   localparam int DivCntW    = $clog2(StateW);

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_ENCODE = 2'd1;
   localparam logic [1:0] FUNC_FLUSH  = 2'd2;

   localparam logic [1:0] CSR_PROB_SCALE   = 2'd0;
   localparam logic [1:0] CSR_LOW_BOUND    = 2'd1;
   localparam logic [1:0] CSR_SYMBOL_COUNT = 2'd2;

   localparam logic [ScaleW-1:0] PROB_SCALE_RST   = 5'd16;
   localparam logic [WordW-1:0]  LOW_BOUND_RST    = 32'h8000_0000;
   localparam logic [CountW-1:0] SYMBOL_COUNT_RST = 9'd256;

endpackage

// ----- hw/rtl/rans64_encoder_top.sv -----
// rANS encoder top level: symbol table, sequencer, bit-serial divider, output word register.
//
//   channel  | direction | handshake             | payload
//   req_     | in        | req_valid / req_stall | req_func, req_symbol, req_freq_value
//   rsp_     | out       | rsp_valid / rsp_stall | rsp_word, rsp_last
//   csr_     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// A load leaves the sequencer idle; a flush passes through ST_FLHI and ST_FLLO, each waiting out any output stall.
// An encode of symbol s reads its frequency, then makes one table read per lower entry
// for the cumulative start, one multiply, one compare, 64 divider steps, two adds.
// Synchronous reset clears control and sets the coder state to the low_bound reset value.
// The output word register frees the input side while a word waits; a word that
// finds the register still stalled holds the sequencer until it drains.
module rans64_encoder_top import rans64_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [SymW-1:0]   req_symbol,
   input  logic [WordW-1:0]  req_freq_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WordW-1:0]  rsp_word,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [WordW-1:0]  csr_wdata
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_FREQ = 4'd1;
   localparam logic [3:0] ST_WALK = 4'd2;
   localparam logic [3:0] ST_MUL  = 4'd3;
   localparam logic [3:0] ST_CMP  = 4'd4;
   localparam logic [3:0] ST_DIV  = 4'd5;
   localparam logic [3:0] ST_ADD1 = 4'd6;
   localparam logic [3:0] ST_ADD2 = 4'd7;
   localparam logic [3:0] ST_FLHI = 4'd8;
   localparam logic [3:0] ST_FLLO = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [ScaleW-1:0]  scale_ff;
   logic [WordW-1:0]   low_bound_ff;
   logic [CountW-1:0]  count_ff;
   logic [StateW-1:0]  x_ff, x_in;
   logic [SymW-1:0]    sym_ff, sym_in;
   logic [SymW-1:0]    idx_ff, idx_in;
   logic [WordW-1:0]   f_ff, f_in;
   logic [StartW-1:0]  start_ff, start_in;
   logic [StateW-1:0]  prod_ff, prod_in;
   logic [StateW-1:0]  qx_ff, qx_in;
   logic [WordW-1:0]   rem_ff, rem_in;
   logic [DivCntW-1:0] div_cnt_ff, div_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WordW-1:0]   rsp_word_ff, rsp_word_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [WordW-1:0]   mem [MaxSymbols];
   logic [WordW-1:0]   rd_data_ff;
   logic [SymW-1:0]    rd_addr;
   logic               mem_we;

   logic               req_acc;
   logic               out_free;
   logic [WordW:0]     trial;
   logic               ge;
   logic [WordW:0]     diff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_last  = rsp_last_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign mem_we = req_acc && (req_func == FUNC_LOAD);

   always_comb begin
      unique case (state_ff)
         ST_IDLE: rd_addr = req_symbol;
         ST_FREQ: rd_addr = '0;
         default: rd_addr = idx_ff + SymW'(1);
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_symbol] <= req_freq_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign trial = {rem_ff, qx_ff[StateW-1]};
   assign ge    = (trial >= {1'b0, f_ff});
   assign diff  = trial - {1'b0, f_ff};

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      sym_in       = sym_ff;
      idx_in       = idx_ff;
      f_in         = f_ff;
      start_in     = start_ff;
      prod_in      = prod_ff;
      qx_in        = qx_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               sym_in = req_symbol;
               if (req_func == FUNC_ENCODE && {1'b0, req_symbol} < count_ff) begin
                  state_in = ST_FREQ;
               end else if (req_func == FUNC_FLUSH) begin
                  state_in = ST_FLHI;
               end
            end
         end
         ST_FREQ: begin
            f_in     = rd_data_ff;
            start_in = '0;
            idx_in   = '0;
            if (rd_data_ff == '0) begin
               state_in = ST_IDLE;
            end else if (sym_ff == '0) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            start_in = start_ff + StartW'(rd_data_ff);
            idx_in   = idx_ff + SymW'(1);
            if (idx_ff == sym_ff - SymW'(1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = StateW'(f_ff) * StateW'(low_bound_ff >> scale_ff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            rem_in     = '0;
            div_cnt_in = '0;
            if (StateW'(x_ff[StateW-1:WordW]) >= prod_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = x_ff[WordW-1:0];
                  rsp_last_in  = 1'b0;
                  qx_in        = StateW'(x_ff[StateW-1:WordW]);
                  state_in     = ST_DIV;
               end
            end else begin
               qx_in    = x_ff;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in     = ge ? diff[WordW-1:0] : trial[WordW-1:0];
            qx_in      = {qx_ff[StateW-2:0], ge};
            div_cnt_in = div_cnt_ff + DivCntW'(1);
            if (div_cnt_ff == {DivCntW{1'b1}}) begin
               state_in = ST_ADD1;
            end
         end
         ST_ADD1: begin
            x_in     = (qx_ff << scale_ff) + StateW'(rem_ff);
            state_in = ST_ADD2;
         end
         ST_ADD2: begin
            x_in     = x_ff + StateW'(start_ff);
            state_in = ST_IDLE;
         end
         ST_FLHI: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = x_ff[StateW-1:WordW];
               rsp_last_in  = 1'b0;
               state_in     = ST_FLLO;
            end
         end
         ST_FLLO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = x_ff[WordW-1:0];
               rsp_last_in  = 1'b1;
               x_in         = StateW'(low_bound_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x_ff         <= StateW'(LOW_BOUND_RST);
         scale_ff     <= PROB_SCALE_RST;
         low_bound_ff <= LOW_BOUND_RST;
         count_ff     <= SYMBOL_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_PROB_SCALE:   scale_ff     <= csr_wdata[ScaleW-1:0];
               CSR_LOW_BOUND:    low_bound_ff <= csr_wdata;
               CSR_SYMBOL_COUNT: count_ff     <= csr_wdata[CountW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      idx_ff      <= idx_in;
      f_ff        <= f_in;
      start_ff    <= start_in;
      prod_ff     <= prod_in;
      qx_ff       <= qx_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ----- hw/rtl/rans64_chk.sv -----
// Port-level checker for the rANS encoder and its bind to the top level.
module rans64_chk import rans64_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [1:0]        req_func,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [WordW-1:0]  rsp_word,
   input logic              rsp_last
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output or input side busy after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word) && $stable(rsp_last))
      else $error("stalled word changed");

   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == FUNC_FLUSH |=> req_stall)
      else $error("flush did not occupy the sequencer");

   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == FUNC_LOAD |=> !req_stall)
      else $error("table load held the input side");

   a_last_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !rsp_stall |=> !(rsp_valid && rsp_last))
      else $error("two last words back to back");

endmodule

bind rans64_encoder_top rans64_chk u_chk (.*);
